@@ hw/rtl/phtc_pkg.sv @@
// ----------------------------------------------------------------------------
// phtc_pkg
// Shared types and constants for the program header table checker.
// ----------------------------------------------------------------------------
package phtc_pkg;

  localparam int unsigned MaxSegments = 128;
  localparam int unsigned SegIdxW     = $clog2(MaxSegments);
  localparam int unsigned SegCntW     = $clog2(MaxSegments + 1);

  localparam logic [63:0] WindowLow  = 64'h0000_0000_0010_0000;
  localparam logic [63:0] WindowHigh = 64'h0000_0001_0000_0000;
  localparam logic [32:0] PageMask33 = 33'h0_0000_0FFF;
  localparam logic [32:0] SpanLimit  = 33'h0_0400_0000;

  localparam logic [31:0] SegLoad   = 32'd1;
  localparam logic [31:0] SegDyn    = 32'd2;
  localparam logic [31:0] SegInterp = 32'd3;

  typedef enum logic [1:0] {
    StRun     = 2'd0,
    StSuccess = 2'd1,
    StUnsupp  = 2'd2,
    StLoadErr = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    RegFileLength = 1'b0,
    RegEntryAddr  = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmScan,
    FsmWait,
    FsmCommit,
    FsmOut
  } fsm_e;

  typedef struct packed {
    logic        first_entry;
    logic        last_entry;
    logic [31:0] segment_type;
    logic        exec_flag;
    logic [63:0] file_offset;
    logic [63:0] virt_addr;
    logic [63:0] phys_addr;
    logic [63:0] file_bytes;
    logic [63:0] mem_bytes;
    logic [63:0] alignment;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        done_res;
    logic [31:0] image_base;
    logic [32:0] image_end;
  } out_item_t;

endpackage

@@ hw/rtl/phtc_seg_mem.sv @@
// ----------------------------------------------------------------------------
// phtc_seg_mem
// Segment store: start and end of each stored segment, one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module phtc_seg_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [phtc_pkg::SegIdxW-1:0] waddr_i,
  input  logic [64:0]                 wdata_i,
  input  logic [phtc_pkg::SegIdxW-1:0] raddr_i,
  output logic [64:0]                 rdata_o
);

  logic [64:0] mem_q [phtc_pkg::MaxSegments];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/program_header_table_checker_core.sv @@
// ----------------------------------------------------------------------------
// program_header_table_checker_core
// Validates program header entries one at a time and reports image bounds.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  in      | in  | in_valid/in_ready | phtc_pkg::in_item_t
//  out     | out | out_valid/ready   | phtc_pkg::out_item_t
//  apb     | in  | psel/penable      | file_length (0x0), entry_address (0x8)
//
// One transaction at a time. Each item passes through the states scan,
// wait, commit and out before the next is accepted, the scan reading the
// stored segments one by one from the segment memory to check for overlap.
// Reset clears all control state; the segment memory is not cleared,
// only entries below the fill count are compared.
// The input stalls while a result waits on the output register.
module program_header_table_checker_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  phtc_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output phtc_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  localparam int unsigned IdxW = phtc_pkg::SegIdxW;
  localparam int unsigned CntW = phtc_pkg::SegCntW;

  // configuration registers
  logic [24:0] file_len_q;
  logic [63:0] entry_addr_q;
  phtc_pkg::reg_idx_e reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = phtc_pkg::reg_idx_e'(paddr[3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q   <= '0;
      entry_addr_q <= '0;
    end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
      unique case (reg_sel)
        phtc_pkg::RegFileLength: file_len_q   <= pwdata[24:0];
        phtc_pkg::RegEntryAddr:  entry_addr_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (reg_sel)
        phtc_pkg::RegFileLength: prdata = {39'd0, file_len_q};
        phtc_pkg::RegEntryAddr:  prdata = entry_addr_q;
        default: ;
      endcase
    end
  end

  // table state
  phtc_pkg::fsm_e   state_q, state_d;
  phtc_pkg::in_item_t item_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [32:0]      span_lo_q, span_lo_d, span_hi_q, span_hi_d;
  logic             seen_q, seen_d;
  logic [1:0]       err_q, err_d;
  logic [CntW-1:0]  scan_q, scan_d;
  logic             hit_q, hit_d;
  logic             ok_q;
  phtc_pkg::out_item_t out_q, out_d;

  // segment checks of the incoming item, registered with it on entry to scan
  logic [63:0] off, va, fsz, msz, al, flen;
  logic        seg_ok;
  always_comb begin
    off  = in_data_i.file_offset;
    va   = in_data_i.virt_addr;
    fsz  = in_data_i.file_bytes;
    msz  = in_data_i.mem_bytes;
    al   = in_data_i.alignment;
    flen = {39'd0, file_len_q};
    seg_ok = 1'b1;
    if (fsz > msz || off > flen) seg_ok = 1'b0;
    if (fsz > flen - off) seg_ok = 1'b0;
    if (in_data_i.phys_addr != va) seg_ok = 1'b0;
    if (va < phtc_pkg::WindowLow || va >= phtc_pkg::WindowHigh) seg_ok = 1'b0;
    if (msz > phtc_pkg::WindowHigh - va) seg_ok = 1'b0;
    if (al > 64'd1) begin
      if ((al & (al - 64'd1)) != '0) seg_ok = 1'b0;
      else if (((va ^ off) & (al - 64'd1)) != '0) seg_ok = 1'b0;
    end
  end

  // memory
  logic            mem_we;
  logic [IdxW-1:0] mem_raddr;
  logic [64:0]     mem_rdata;
  logic [32:0]     seg_end;
  assign seg_end = item_q.virt_addr[32:0] + item_q.mem_bytes[32:0];

  phtc_seg_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i ({item_q.virt_addr[31:0], seg_end}),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= phtc_pkg::FsmIdle;
      cnt_q     <= '0;
      span_lo_q <= '1;
      span_hi_q <= '0;
      seen_q    <= 1'b0;
      err_q     <= '0;
      scan_q    <= '0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      span_lo_q <= span_lo_d;
      span_hi_q <= span_hi_d;
      seen_q    <= seen_d;
      err_q     <= err_d;
      scan_q    <= scan_d;
      hit_q     <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
      ok_q   <= seg_ok;
    end
    out_q <= out_d;
  end

  // sequencer
  logic [32:0] pb, pe;
  logic        ent;
  logic [63:0] ea_off;
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    span_lo_d = span_lo_q;
    span_hi_d = span_hi_q;
    seen_d    = seen_q;
    err_d     = err_q;
    scan_d    = scan_q;
    hit_d     = hit_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_raddr = scan_q[IdxW-1:0];
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    pb = item_q.virt_addr[32:0] & ~phtc_pkg::PageMask33;
    pe = (seg_end + phtc_pkg::PageMask33) & ~phtc_pkg::PageMask33;
    ea_off = entry_addr_q - item_q.virt_addr;
    ent = item_q.exec_flag && entry_addr_q >= item_q.virt_addr &&
          ea_off < item_q.file_bytes;
    unique case (state_q)
      phtc_pkg::FsmIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_data_i.first_entry) begin
            cnt_d = '0; span_lo_d = '1; span_hi_d = '0; seen_d = 1'b0; err_d = '0;
          end
          scan_d = '0;
          hit_d  = 1'b0;
          state_d = phtc_pkg::FsmScan;
        end
      end
      phtc_pkg::FsmScan: begin
        // issue one read per cycle; compare the data in the next cycle
        if (scan_q != '0 && item_q.virt_addr[32:0] < mem_rdata[32:0] &&
            {1'b0, mem_rdata[64:33]} < seg_end) begin
          hit_d = 1'b1;
        end
        if (err_q != '0 || item_q.segment_type != phtc_pkg::SegLoad || !ok_q ||
            item_q.mem_bytes == '0 || scan_q >= cnt_q) begin
          state_d = phtc_pkg::FsmWait;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      phtc_pkg::FsmWait: begin
        state_d = phtc_pkg::FsmCommit;
      end
      phtc_pkg::FsmCommit: begin
        if (err_q == '0) begin
          if (item_q.segment_type == phtc_pkg::SegDyn ||
              item_q.segment_type == phtc_pkg::SegInterp) begin
            err_d = phtc_pkg::StUnsupp;
          end else if (item_q.segment_type == phtc_pkg::SegLoad) begin
            if (!ok_q) begin
              err_d = phtc_pkg::StLoadErr;
            end else if (item_q.mem_bytes != '0) begin
              if (hit_q || cnt_q >= CntW'(phtc_pkg::MaxSegments)) begin
                err_d = phtc_pkg::StLoadErr;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
                if (ent) seen_d = 1'b1;
                if (pb < span_lo_q) span_lo_d = pb;
                if (pe > span_hi_q) span_hi_d = pe;
              end
            end
          end
        end
        out_d = '0;
        out_d.done_res = item_q.last_entry;
        if (err_d != '0) begin
          out_d.status = err_d;
        end else if (item_q.last_entry) begin
          if (seen_d && span_hi_d > span_lo_d &&
              span_hi_d - span_lo_d <= phtc_pkg::SpanLimit) begin
            out_d.status     = phtc_pkg::StSuccess;
            out_d.image_base = span_lo_d[31:0];
            out_d.image_end  = span_hi_d;
          end else begin
            err_d        = phtc_pkg::StLoadErr;
            out_d.status = phtc_pkg::StLoadErr;
          end
        end
        state_d = phtc_pkg::FsmOut;
      end
      phtc_pkg::FsmOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = phtc_pkg::FsmIdle;
      end
      default: state_d = phtc_pkg::FsmIdle;
    endcase
  end

  assign out_data_o = out_q;

endmodule

@@ dv/program_header_table_checker_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// program_header_table_checker_core_tb
// Drives program header tables through the checker, predicts each result
// and compares it field by field. Both channels idle at random, and the
// two registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module program_header_table_checker_core_tb;
  import phtc_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam logic [63:0] Mask33 = 64'h1_FFFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_item_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_item_t out_data_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [3:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  program_header_table_checker_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Predictor state
  logic [63:0] file_len_q;
  logic [63:0] entry_addr_q;
  logic [31:0] seg_lo_q[MaxSegments];
  logic [63:0] seg_hi_q[MaxSegments];
  int unsigned seg_cnt_q;
  logic [63:0] span_lo_q;
  logic [63:0] span_hi_q;
  bit entry_hit_q;
  logic [1:0] err_q;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit cfg_busy;
  bit driving_done;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit seg_legal(in_item_t t);
    logic [63:0] am;
    if (t.file_bytes > t.mem_bytes || t.file_offset > file_len_q) return 0;
    if (t.file_bytes > file_len_q - t.file_offset) return 0;
    if (t.phys_addr != t.virt_addr) return 0;
    if (t.virt_addr < WindowLow || t.virt_addr >= WindowHigh) return 0;
    if (t.mem_bytes > WindowHigh - t.virt_addr) return 0;
    if (t.alignment <= 1) return 1;
    am = t.alignment - 1;
    if ((t.alignment & am) != 0) return 0;
    return (t.virt_addr & am) == (t.file_offset & am);
  endfunction

  function automatic out_item_t check_entry(in_item_t t);
    out_item_t r;
    logic [63:0] seg_top, b, e;
    bit hit;
    r = '0;
    if (t.first_entry) begin
      seg_cnt_q = 0;
      span_lo_q = Mask33;
      span_hi_q = 0;
      entry_hit_q = 0;
      err_q = StRun;
    end
    if (err_q == StRun) begin
      if (t.segment_type == SegDyn || t.segment_type == SegInterp) begin
        err_q = StUnsupp;
      end else if (t.segment_type == SegLoad) begin
        if (!seg_legal(t)) begin
          err_q = StLoadErr;
        end else if (t.mem_bytes != 0) begin
          seg_top = t.virt_addr + t.mem_bytes;
          hit = 0;
          for (int i = 0; i < seg_cnt_q; i++)
            if (t.virt_addr < seg_hi_q[i] && {32'd0, seg_lo_q[i]} < seg_top) hit = 1;
          if (hit || seg_cnt_q >= MaxSegments) begin
            err_q = StLoadErr;
          end else begin
            seg_lo_q[seg_cnt_q] = t.virt_addr[31:0];
            seg_hi_q[seg_cnt_q] = seg_top & Mask33;
            seg_cnt_q++;
            if (t.exec_flag && entry_addr_q >= t.virt_addr &&
                entry_addr_q - t.virt_addr < t.file_bytes) entry_hit_q = 1;
            b = t.virt_addr & ~64'hFFF;
            e = (seg_top + 64'hFFF) & ~64'hFFF;
            if (b < span_lo_q) span_lo_q = b;
            if (e > span_hi_q) span_hi_q = e;
          end
        end
      end
    end
    if (err_q != StRun) begin
      r.status = err_q;
    end else if (t.last_entry) begin
      if (entry_hit_q && span_hi_q > span_lo_q && span_hi_q - span_lo_q <= SpanLimit) begin
        r.status = StSuccess;
        r.image_base = span_lo_q[31:0];
        r.image_end = span_hi_q[32:0];
      end else begin
        err_q = StLoadErr;
        r.status = StLoadErr;
      end
    end
    r.done_res = t.last_entry;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Input driver: predicts each transaction as it is accepted
  int unsigned in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      in_gap <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(check_entry(in_data_i));
        void'(pending_items.pop_front());
      end
      if (in_valid_i && !in_ready_o) begin
        // hold
      end else if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > (in_valid_i && in_ready_o ? 0 : 0) &&
                   pending_items.size() != 0 && !cfg_busy) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_items[0];
        in_gap <= gap_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output monitor and stall generator
  int unsigned out_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data_o);
        end else begin
          out_item_t x;
          x = expected_results.pop_front();
          if (x.status !== out_data_o.status || x.done_res !== out_data_o.done_res ||
              x.image_base !== out_data_o.image_base ||
              x.image_end !== out_data_o.image_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d done=%0d base=%h end=%h act st=%0d done=%0d base=%h end=%h",
                       x.status, x.done_res, x.image_base, x.image_end, out_data_o.status,
                       out_data_o.done_res, out_data_o.image_base, out_data_o.image_end);
          end
        end
      end
      if (out_gap != 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        out_gap <= gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic apb_write(input reg_idx_e idx, input logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 3; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == RegFileLength) file_len_q = val & 64'h1FF_FFFF;
    else entry_addr_q = val;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_noise();
    in_item_t t;
    logic [447:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    t = raw[$bits(in_item_t)-1:0];
    if ($urandom_range(0, 1)) t.segment_type = $urandom_range(0, 4);
    return t;
  endfunction

  // Well-formed loadable entry placed at a given address
  function automatic in_item_t good_seg(logic [63:0] va, logic [63:0] sz, bit ex);
    in_item_t t;
    t = '0;
    t.segment_type = SegLoad;
    t.exec_flag = ex;
    t.virt_addr = va;
    t.phys_addr = va;
    t.mem_bytes = sz;
    t.file_bytes = (file_len_q < sz) ? file_len_q : $urandom_range(0, 32'(sz));
    t.file_offset = va & 64'hFFF;
    if (t.file_offset + t.file_bytes > file_len_q) begin
      t.file_offset = 0;
      if (t.file_bytes > file_len_q) t.file_bytes = file_len_q;
    end
    t.alignment = (t.file_offset == (va & 64'hFFF)) ? 64'h1000 : 64'd0;
    return t;
  endfunction

  task automatic push_table(int unsigned n);
    logic [63:0] va;
    in_item_t t;
    va = 64'h10_0000 + ($urandom_range(0, 255) << 12) + $urandom_range(0, 15);
    for (int i = 0; i < n; i++) begin
      int unsigned sz;
      sz = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 16'hFFFF);
      t = good_seg(va, sz, i == 0 || $urandom_range(0, 1));
      if (i == 0) begin
        t.file_bytes = (sz > 1 && file_len_q > 16) ? 2 : t.file_bytes;
        t.file_offset = 0;
        t.alignment = $urandom_range(0, 1);
      end
      case ($urandom_range(0, 15))
        0: t = rand_noise();
        1: t.segment_type = $urandom_range(0, 1) ? SegDyn : SegInterp;
        2: t.segment_type = $urandom_range(4, 32'hFFFF_FFFF);
        3: t.phys_addr[$urandom_range(0, 63)] ^= 1'b1;
        4: t.virt_addr = va - 16;
        5: t.alignment = $urandom_range(3, 255);
        default: ;
      endcase
      t.first_entry = (i == 0);
      t.last_entry = (i == n - 1);
      pending_items.push_back(t);
      va = va + sz + $urandom_range(0, 1) * $urandom_range(0, 8192);
    end
  endtask

  initial begin
    in_item_t t;
    int unsigned sent;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    cycles = 0; mismatches = 0; cfg_busy = 1; driving_done = 0;
    file_len_q = 0; entry_addr_q = 0; seg_cnt_q = 0;
    span_lo_q = Mask33; span_hi_q = 0; entry_hit_q = 0; err_q = StRun;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes and special cases
    apb_write(RegFileLength, 64'h100_0000);
    apb_write(RegEntryAddr, 64'h10_0000);
    t = good_seg(64'h10_0000, 64'h1000, 1); t.file_bytes = 16; t.file_offset = 0;
    t.alignment = 0; t.first_entry = 1; pending_items.push_back(t);
    t = good_seg(64'h10_0800, 64'h100, 0); t.file_offset = 0; t.alignment = 1;
    pending_items.push_back(t);                      // overlap: sticky load error
    t.segment_type = SegDyn; pending_items.push_back(t);
    t.last_entry = 1; pending_items.push_back(t);
    t = good_seg(64'h10_0000, 64'h1000, 1); t.file_bytes = 16; t.file_offset = 0;
    t.alignment = 64'h8000_0000_0000_0000; t.first_entry = 1; t.last_entry = 1;
    pending_items.push_back(t);
    t.alignment = 0; t.last_entry = 0; pending_items.push_back(t);
    t = good_seg(64'hFFFF_F000, 64'h1000, 0); t.file_offset = 0; t.alignment = 0;
    t.last_entry = 1; pending_items.push_back(t);    // span too wide: final check fails
    t = '1; pending_items.push_back(t);
    t = '0; t.segment_type = SegInterp; t.first_entry = 1; pending_items.push_back(t);
    t = '0; t.first_entry = 1; t.last_entry = 1; pending_items.push_back(t);
    t = good_seg(64'h10_0000, 64'h1000, 1); t.file_bytes = 16; t.file_offset = 0;
    t.alignment = 0; t.first_entry = 1; pending_items.push_back(t);
    t.first_entry = 0; t.last_entry = 1; t.mem_bytes = 0; t.file_bytes = 0;
    t.segment_type = 32'hFFFF_FFFF; pending_items.push_back(t);
    t.segment_type = 0; pending_items.push_back(t);  // continues after last
    cfg_busy = 0;
    wait_idle();

    // Store full: 130 small segments
    cfg_busy = 1;
    apb_write(RegEntryAddr, 64'h20_0000);
    for (int i = 0; i < MaxSegments + 2; i++) begin
      t = good_seg(64'h20_0000 + i * 64'h1000, 64'h10, 1);
      t.file_offset = 0; t.file_bytes = 4; t.alignment = 0;
      t.first_entry = (i == 0); t.last_entry = (i == MaxSegments + 1);
      pending_items.push_back(t);
    end
    cfg_busy = 0;
    wait_idle();

    // Random phases with varying register settings
    sent = 0;
    for (int ph = 0; sent < 1000; ph++) begin
      cfg_busy = 1;
      case (ph % 4)
        0: apb_write(RegFileLength, 64'h100_0000);
        1: apb_write(RegFileLength, {$urandom, $urandom});
        2: apb_write(RegFileLength, 64'd0);
        default: apb_write(RegFileLength, $urandom_range(0, 32'hFFFFF));
      endcase
      for (int k = 0; k < 40; k++) begin
        int unsigned n;
        n = $urandom_range(1, 6);
        sent += n;
        push_table(n);
      end
      t = pending_items[0];
      apb_write(RegEntryAddr, ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                : t.virt_addr + $urandom_range(0, 1));
      if (ph % 5 == 4) apb_write(RegEntryAddr, 64'hFFFF_FFFF_FFFF_FFFF);
      for (int k = 0; k < 10; k++) begin
        pending_items.push_back(rand_noise());
        sent++;
      end
      cfg_busy = 0;
      wait_idle();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
